// ===== hdl/tppi_pkg.sv =====
package tppi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int STEP_GAIN = 65536;
  localparam logic signed [31:0] PITCH_DRIVE_MAX = 32'sd131072000;
  localparam logic signed [31:0] PITCH_DRIVE_MIN = 32'sd65536000;
  localparam logic signed [31:0] ROLL_DRIVE_MAX  = 32'sd131072000;
  localparam logic signed [31:0] ROLL_DRIVE_MIN  = 32'sd65536000;

  localparam int DIV_STEPS = 32;

  // datapath operations
  localparam logic [4:0] OP_NOP   = 5'd0;
  localparam logic [4:0] OP_LOAD  = 5'd1;
  localparam logic [4:0] OP_DT    = 5'd2;
  localparam logic [4:0] OP_ERR   = 5'd3;
  localparam logic [4:0] OP_MP    = 5'd4;
  localparam logic [4:0] OP_MH    = 5'd5;
  localparam logic [4:0] OP_HS    = 5'd6;
  localparam logic [4:0] OP_MHDT  = 5'd7;
  localparam logic [4:0] OP_MD    = 5'd8;
  localparam logic [4:0] OP_DIVST = 5'd9;
  localparam logic [4:0] OP_DIV   = 5'd10;
  localparam logic [4:0] OP_DEND  = 5'd11;
  localparam logic [4:0] OP_EFF   = 5'd12;
  localparam logic [4:0] OP_MS    = 5'd13;
  localparam logic [4:0] OP_SS    = 5'd14;
  localparam logic [4:0] OP_MSDT  = 5'd15;
  localparam logic [4:0] OP_ACC   = 5'd16;
  localparam logic [4:0] OP_PUB   = 5'd17;

  typedef struct packed {
    logic signed [31:0] pitch_kp;
    logic signed [31:0] pitch_ki;
    logic signed [31:0] pitch_kd;
    logic signed [31:0] roll_kp;
    logic signed [31:0] roll_ki;
    logic signed [31:0] roll_kd;
    logic signed [31:0] effort_max;
    logic signed [31:0] effort_min;
  } cfg_t;

  typedef struct packed {
    logic [4:0] op;
    logic       axis;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
  } sts_t;

endpackage

// ===== hdl/tppi_regs.sv =====
module tppi_regs
  import tppi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg
);

  localparam logic [2:0] REG_PITCH_KP = 3'd0;
  localparam logic [2:0] REG_PITCH_KI = 3'd1;
  localparam logic [2:0] REG_PITCH_KD = 3'd2;
  localparam logic [2:0] REG_ROLL_KP  = 3'd3;
  localparam logic [2:0] REG_ROLL_KI  = 3'd4;
  localparam logic [2:0] REG_ROLL_KD  = 3'd5;
  localparam logic [2:0] REG_EFF_MAX  = 3'd6;
  localparam logic [2:0] REG_EFF_MIN  = 3'd7;

  logic [2:0] idx;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pitch_kp   <= '0;
      cfg.pitch_ki   <= '0;
      cfg.pitch_kd   <= '0;
      cfg.roll_kp    <= '0;
      cfg.roll_ki    <= '0;
      cfg.roll_kd    <= '0;
      cfg.effort_max <= 32'sh7FFF_FFFF;
      cfg.effort_min <= 32'sh8000_0000;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_PITCH_KP: cfg.pitch_kp   <= pwdata;
        REG_PITCH_KI: cfg.pitch_ki   <= pwdata;
        REG_PITCH_KD: cfg.pitch_kd   <= pwdata;
        REG_ROLL_KP:  cfg.roll_kp    <= pwdata;
        REG_ROLL_KI:  cfg.roll_ki    <= pwdata;
        REG_ROLL_KD:  cfg.roll_kd    <= pwdata;
        REG_EFF_MAX:  cfg.effort_max <= pwdata;
        REG_EFF_MIN:  cfg.effort_min <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PITCH_KP: prdata = cfg.pitch_kp;
      REG_PITCH_KI: prdata = cfg.pitch_ki;
      REG_PITCH_KD: prdata = cfg.pitch_kd;
      REG_ROLL_KP:  prdata = cfg.roll_kp;
      REG_ROLL_KI:  prdata = cfg.roll_ki;
      REG_ROLL_KD:  prdata = cfg.roll_kd;
      REG_EFF_MAX:  prdata = cfg.effort_max;
      REG_EFF_MIN:  prdata = cfg.effort_min;
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== hdl/tppi_ctrl.sv =====
module tppi_ctrl
  import tppi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DT    = 5'd1;
  localparam logic [4:0] S_ERR   = 5'd2;
  localparam logic [4:0] S_MP    = 5'd3;
  localparam logic [4:0] S_MH    = 5'd4;
  localparam logic [4:0] S_HS    = 5'd5;
  localparam logic [4:0] S_MHDT  = 5'd6;
  localparam logic [4:0] S_MD    = 5'd7;
  localparam logic [4:0] S_DIVST = 5'd8;
  localparam logic [4:0] S_DIV   = 5'd9;
  localparam logic [4:0] S_DEND  = 5'd10;
  localparam logic [4:0] S_EFF   = 5'd11;
  localparam logic [4:0] S_MS    = 5'd12;
  localparam logic [4:0] S_SS    = 5'd13;
  localparam logic [4:0] S_MSDT  = 5'd14;
  localparam logic [4:0] S_ACC   = 5'd15;
  localparam logic [4:0] S_PUB   = 5'd16;

  localparam logic [4:0] CNT_LAST = 5'(DIV_STEPS - 1);

  logic [4:0] state, state_next;
  logic       axis, axis_next;
  logic [4:0] cnt, cnt_next;
  logic       pub_ok;

  assign s_tready = (state == S_IDLE);
  assign pub_ok   = (state == S_PUB) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cnt_next   = cnt;
    cmd.op     = OP_NOP;
    cmd.axis   = axis;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DT;
        end
      end
      S_DT: begin
        cmd.op = OP_DT; axis_next = 1'b0; state_next = S_ERR;
      end
      S_ERR:  begin cmd.op = OP_ERR;  state_next = S_MP;   end
      S_MP:   begin cmd.op = OP_MP;   state_next = S_MH;   end
      S_MH:   begin cmd.op = OP_MH;   state_next = S_HS;   end
      S_HS:   begin cmd.op = OP_HS;   state_next = S_MHDT; end
      S_MHDT: begin cmd.op = OP_MHDT; state_next = S_MD;   end
      S_MD:   begin cmd.op = OP_MD;   state_next = S_DIVST; end
      S_DIVST: begin
        cmd.op   = OP_DIVST;
        cnt_next = '0;
        state_next = sts.dt_zero ? S_EFF : S_DIV;
      end
      S_DIV: begin
        cmd.op   = OP_DIV;
        cnt_next = cnt + 5'd1;
        if (cnt == CNT_LAST) state_next = S_DEND;
      end
      S_DEND: begin cmd.op = OP_DEND; state_next = S_EFF;  end
      S_EFF:  begin cmd.op = OP_EFF;  state_next = S_MS;   end
      S_MS:   begin cmd.op = OP_MS;   state_next = S_SS;   end
      S_SS:   begin cmd.op = OP_SS;   state_next = S_MSDT; end
      S_MSDT: begin cmd.op = OP_MSDT; state_next = S_ACC;  end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_ERR;
        end else begin
          state_next = S_PUB;
        end
      end
      S_PUB: begin
        if (pub_ok) begin
          cmd.op     = OP_PUB;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      axis     <= 1'b0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      cnt   <= cnt_next;
      if (pub_ok)        m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

// ===== hdl/tppi_dp.sv =====
module tppi_dp
  import tppi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [159:0] s_tdata,
  input  cfg_t         cfg,
  input  cmd_t         cmd,
  output sts_t         sts,
  output logic [127:0] m_tdata
);

  function automatic logic signed [35:0] sx36(input logic signed [31:0] v);
    return {{4{v[31]}}, v};
  endfunction

  function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  function automatic logic [32:0] mag34(input logic signed [33:0] v);
    logic [33:0] n;
    n = v[33] ? (~v + 34'd1) : v;
    return n[32:0];
  endfunction

  function automatic logic signed [31:0] sat_s(input logic signed [35:0] x);
    if (x > 36'sh0_7FFF_FFFF)      return 32'sh7FFF_FFFF;
    else if (x < -36'sh0_8000_0000) return 32'sh8000_0000;
    else                            return x[31:0];
  endfunction

  // sign-magnitude to saturated two's complement
  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [65:0] m);
    if (neg) begin
      if (m > 66'h0_8000_0000) return 32'sh8000_0000;
      else                     return ~m[31:0] + 32'd1;
    end else begin
      if (m > 66'h0_7FFF_FFFF) return 32'sh7FFF_FFFF;
      else                     return m[31:0];
    end
  endfunction

  function automatic logic signed [31:0] clamp_eff(input logic signed [35:0] x,
                                                   input logic signed [31:0] hi,
                                                   input logic signed [31:0] lo);
    if (x > sx36(hi))      return hi;
    else if (x < sx36(lo)) return lo;
    else                   return x[31:0];
  endfunction

  localparam logic signed [33:0] GAIN_OP  = 34'(STEP_GAIN);
  localparam logic [32:0]        BIG_EFF  = 33'(4) << FRAC_BITS;
  localparam logic [65:0]        DIV_OVF  = 66'h1_0000_0000;

  // captured beat
  logic [31:0]        ts;
  logic signed [31:0] tgt [2];
  logic signed [31:0] meas [2];

  // persistent state
  logic [31:0]        last_time;
  logic [31:0]        dt;
  logic signed [31:0] integ [2];
  logic signed [31:0] last_err [2];
  logic signed [31:0] accum [2];
  logic signed [31:0] eff_st [2];

  // working registers
  logic signed [31:0] err, p, h, i_term, d, eff, s;
  logic [65:0]        prod;
  logic               prod_neg;
  logic [31:0]        rem, quo;
  logic               ovf, dneg;

  logic               ax;
  logic signed [31:0] kp, ki, kd, drv_max, drv_min;
  logic signed [33:0] mul_a, mul_b;
  logic signed [31:0] shs, shs1, i_calc, acc_calc, acc_clamp;
  logic signed [35:0] eff_sum;
  logic [32:0]        div_tmp;
  logic               div_bit;

  assign ax  = cmd.axis;
  assign kp  = ax ? cfg.roll_kp : cfg.pitch_kp;
  assign ki  = ax ? cfg.roll_ki : cfg.pitch_ki;
  assign kd  = ax ? cfg.roll_kd : cfg.pitch_kd;
  assign drv_max = ax ? ROLL_DRIVE_MAX : PITCH_DRIVE_MAX;
  assign drv_min = ax ? ROLL_DRIVE_MIN : PITCH_DRIVE_MIN;

  assign sts.dt_zero = (dt == '0);

  always_comb begin
    unique case (cmd.op)
      OP_MP:   begin mul_a = sx34(kp); mul_b = sx34(err); end
      OP_MH:   begin mul_a = sx34(ki); mul_b = sx34(err) + sx34(last_err[ax]); end
      OP_MHDT: begin mul_a = sx34(h);  mul_b = {2'b00, dt}; end
      OP_MD:   begin mul_a = sx34(kd); mul_b = sx34(err) - sx34(last_err[ax]); end
      OP_MS:   begin mul_a = GAIN_OP;  mul_b = sx34(eff); end
      OP_MSDT: begin mul_a = sx34(s);  mul_b = {2'b00, dt}; end
      default: begin mul_a = '0;       mul_b = '0; end
    endcase
  end

  assign shs      = sat_mag(prod_neg, prod >> FRAC_BITS);
  assign shs1     = sat_mag(prod_neg, prod >> (FRAC_BITS + 1));
  assign i_calc   = clamp_eff(sx36(sat_s(sx36(integ[ax]) + sx36(shs))),
                              cfg.effort_max, cfg.effort_min);
  assign eff_sum  = sx36(p) + sx36(i_term) + sx36(d);

  assign div_tmp  = {rem, quo[31]};
  assign div_bit  = (div_tmp >= {1'b0, dt});

  always_comb begin
    acc_calc = accum[ax];
    if (mag34(sx34(eff)) > BIG_EFF) acc_calc = sat_s(sx36(accum[ax]) + sx36(shs));
    acc_clamp = acc_calc;
    if (acc_clamp > drv_max) acc_clamp = drv_max;
    if (acc_clamp < drv_min) acc_clamp = drv_min;
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    prod     <= {33'b0, mag34(mul_a)} * {33'b0, mag34(mul_b)};
    prod_neg <= mul_a[33] ^ mul_b[33];
    unique case (cmd.op)
      OP_LOAD: begin
        ts      <= s_tdata[31:0];
        tgt[0]  <= s_tdata[63:32];
        meas[0] <= s_tdata[95:64];
        tgt[1]  <= s_tdata[127:96];
        meas[1] <= s_tdata[159:128];
      end
      OP_ERR:  err    <= sat_s(sx36(tgt[ax]) - sx36(meas[ax]));
      OP_MH:   p      <= shs;
      OP_HS:   h      <= shs1;
      OP_MD:   i_term <= i_calc;
      OP_DIVST: begin
        d    <= '0;
        rem  <= prod[63:32];
        quo  <= prod[31:0];
        ovf  <= (prod[63:32] >= dt);
        dneg <= prod_neg;
      end
      OP_DIV: begin
        rem <= div_bit ? 32'(div_tmp - {1'b0, dt}) : div_tmp[31:0];
        quo <= {quo[30:0], div_bit};
      end
      OP_DEND: d   <= sat_mag(dneg, ovf ? DIV_OVF : {34'b0, quo});
      OP_EFF:  eff <= clamp_eff(eff_sum, cfg.effort_max, cfg.effort_min);
      OP_SS:   s   <= shs;
      OP_PUB:  m_tdata <= {eff_st[1], eff_st[0], accum[1], accum[0]};
      default: ;
    endcase
  end

  // controller state that reset clears
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time   <= '0;
      dt          <= '0;
      integ[0]    <= '0;
      integ[1]    <= '0;
      last_err[0] <= '0;
      last_err[1] <= '0;
      accum[0]    <= '0;
      accum[1]    <= '0;
      eff_st[0]   <= '0;
      eff_st[1]   <= '0;
    end else begin
      unique case (cmd.op)
        OP_DT: begin
          dt        <= ts - last_time;
          last_time <= ts;
        end
        OP_EFF: begin
          integ[ax]    <= i_term;
          last_err[ax] <= err;
          eff_st[ax]   <= clamp_eff(eff_sum, cfg.effort_max, cfg.effort_min);
        end
        OP_ACC:  accum[ax] <= acc_clamp;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/two_axis_pid_pwm_integrator.sv =====
// channel   direction  beat contents (lowest bits first)
// s_axis    in         timestamp, pitch_target, pitch_measured, roll_target, roll_measured
// m_axis    out        pitch_drive, roll_drive, pitch_effort, roll_effort
// apb       in/out     8 x 32-bit registers at 4*i, writes on psel&penable&pwrite
//
// One item at a time: the next beat is taken only once the result of the last one is
// handed to the output register. Each item runs through the shared 33x33 multiplier
// (6 products per axis) and the 1 bit per cycle divider for the derivative term,
// which is skipped when dt is zero.
// Reset is synchronous; gains clear, effort limits open fully, all controller state zero.
// A waiting result sits in the output register; the next beat is taken meanwhile.
module two_axis_pid_pwm_integrator
  import tppi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // timestamp, pitch_target, pitch_measured, roll_target, roll_measured
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pitch_drive, roll_drive, pitch_effort, roll_effort
  output logic [127:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  tppi_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
  );

  tppi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .sts(sts), .cmd(cmd)
  );

  tppi_dp u_dp (
    .clk(clk), .rst(rst), .s_tdata(s_tdata), .cfg(cfg), .cmd(cmd),
    .sts(sts), .m_tdata(m_tdata)
  );

endmodule

// ===== hdl/tppi_check.sv =====
module tppi_check (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic         pready
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed under stall");

  // one item in flight
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second beat taken while busy");

  // a result cannot appear straight after a beat is taken
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result raised too early");

  a_rdy: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind two_axis_pid_pwm_integrator tppi_check u_check (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
  import tppi_pkg::*;
();

  localparam int REG_PITCH_KP   = 0;
  localparam int REG_PITCH_KI   = 1;
  localparam int REG_PITCH_KD   = 2;
  localparam int REG_ROLL_KP    = 3;
  localparam int REG_ROLL_KI    = 4;
  localparam int REG_ROLL_KD    = 5;
  localparam int REG_EFFORT_MAX = 6;
  localparam int REG_EFFORT_MIN = 7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;

  typedef struct packed {
    logic signed [31:0] roll_measured;
    logic signed [31:0] roll_target;
    logic signed [31:0] pitch_measured;
    logic signed [31:0] pitch_target;
    logic [31:0]        timestamp;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] roll_effort;
    logic signed [31:0] pitch_effort;
    logic signed [31:0] roll_drive;
    logic signed [31:0] pitch_drive;
  } drive_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [127:0] m_tdata;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  two_axis_pid_pwm_integrator uut (.*);

  always #2 clk = ~clk;

  // predictor state
  longint gain_kp [2], gain_ki [2], gain_kd [2];
  longint eff_hi, eff_lo;
  longint stamp_last;
  longint integ [2], prev_err [2], accum [2];

  drive_t expected_q[$];
  int     fail_count = 0;
  int     results_seen = 0;
  int     items_sent = 0;
  int     idle_run_cycles = 0;
  bit     sink_jitter = 1;
  bit     src_jitter = 1;
  bit     sink_hold = 0;

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint magnitude(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic longint apply_sign(bit neg, logic [63:0] m);
    if (neg) return (m > 64'd2147483648) ? -64'sd2147483648 : -longint'(m);
    return (m > 64'd2147483647) ? 64'sd2147483647 : longint'(m);
  endfunction

  function automatic longint mul_shr(longint a, longint b, int sh);
    logic [63:0] m;
    m = (64'(magnitude(a)) * 64'(magnitude(b))) >> sh;
    return apply_sign((a < 0) != (b < 0), m);
  endfunction

  function automatic longint mul_over(longint a, longint b, longint den);
    logic [63:0] m;
    m = (64'(magnitude(a)) * 64'(magnitude(b))) / 64'(den);
    return apply_sign((a < 0) != (b < 0), m);
  endfunction

  function automatic longint effort_clamp(longint x);
    if (x > eff_hi) return eff_hi;
    if (x < eff_lo) return eff_lo;
    return x;
  endfunction

  function automatic longint axis_effort(int ax, longint tgt, longint meas, longint dt);
    longint err, p, h, i, d, eff, s;
    err = sat32(tgt - meas);
    p = mul_shr(gain_kp[ax], err, FRAC_BITS);
    h = mul_shr(gain_ki[ax], err + prev_err[ax], FRAC_BITS + 1);
    i = effort_clamp(sat32(integ[ax] + mul_shr(h, dt, FRAC_BITS)));
    d = (dt != 0) ? mul_over(gain_kd[ax], err - prev_err[ax], dt) : 0;
    eff = effort_clamp(p + i + d);
    integ[ax] = i;
    prev_err[ax] = err;
    if (magnitude(eff) > (64'sd4 << FRAC_BITS)) begin
      s = mul_shr(STEP_GAIN, eff, FRAC_BITS);
      accum[ax] = sat32(accum[ax] + mul_shr(s, dt, FRAC_BITS));
    end
    return eff;
  endfunction

  function automatic longint drive_clamp(longint x, longint hi, longint lo);
    if (x > hi) x = hi;
    if (x < lo) x = lo;
    return x;
  endfunction

  function automatic drive_t predict_drive(sample_t s);
    drive_t r;
    longint dt;
    dt = longint'(32'(s.timestamp - 32'(stamp_last)));
    stamp_last = s.timestamp;
    r.pitch_effort = 32'(axis_effort(0, s.pitch_target, s.pitch_measured, dt));
    r.roll_effort  = 32'(axis_effort(1, s.roll_target, s.roll_measured, dt));
    accum[0] = drive_clamp(accum[0], PITCH_DRIVE_MAX, PITCH_DRIVE_MIN);
    accum[1] = drive_clamp(accum[1], ROLL_DRIVE_MAX, ROLL_DRIVE_MIN);
    r.pitch_drive = 32'(accum[0]);
    r.roll_drive  = 32'(accum[1]);
    return r;
  endfunction

  task automatic write_reg(int idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(4 * idx); pwdata <= val;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_PITCH_KP:   gain_kp[0] = longint'(signed'(val));
      REG_PITCH_KI:   gain_ki[0] = longint'(signed'(val));
      REG_PITCH_KD:   gain_kd[0] = longint'(signed'(val));
      REG_ROLL_KP:    gain_kp[1] = longint'(signed'(val));
      REG_ROLL_KI:    gain_ki[1] = longint'(signed'(val));
      REG_ROLL_KD:    gain_kd[1] = longint'(signed'(val));
      REG_EFFORT_MAX: eff_hi = longint'(signed'(val));
      REG_EFFORT_MIN: eff_lo = longint'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic set_gains(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                           logic [31:0] hi, logic [31:0] lo);
    write_reg(REG_PITCH_KP, kp);
    write_reg(REG_PITCH_KI, ki);
    write_reg(REG_PITCH_KD, kd);
    write_reg(REG_ROLL_KP, kp ^ 32'h0000_8000);
    write_reg(REG_ROLL_KI, ki);
    write_reg(REG_ROLL_KD, kd);
    write_reg(REG_EFFORT_MAX, hi);
    write_reg(REG_EFFORT_MIN, lo);
  endtask

  // sender: beat stays offered until accepted
  task automatic send_sample(sample_t s);
    @(negedge clk);
    if (src_jitter && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 7)) @(negedge clk);
    s_tvalid <= 1;
    s_tdata  <= s;
    do @(posedge clk); while (!s_tready);
    expected_q.push_back(predict_drive(s));
    items_sent++;
    @(negedge clk);
    s_tvalid <= 0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 20 << 16)) - (10 << 16));
      default: return $urandom;
    endcase
  endfunction

  int ts_now = 0;

  function automatic sample_t rand_sample(int dt_mode);
    sample_t s;
    case (dt_mode)
      0: ts_now = ts_now;
      1: ts_now = ts_now + $urandom_range(1, 1 << 14);
      2: ts_now = $urandom;
      default: ts_now = ts_now + $urandom_range(1 << 10, 1 << 17);
    endcase
    s.timestamp = ts_now;
    s.pitch_target = rand_word();
    s.pitch_measured = rand_word();
    s.roll_target = rand_word();
    s.roll_measured = rand_word();
    return s;
  endfunction

  // receiver: random stalls, long hold-off on request
  always @(negedge clk) begin
    if (rst || sink_hold) m_tready <= 0;
    else if (sink_jitter && $urandom_range(0, 3) == 0) m_tready <= 0;
    else m_tready <= 1;
  end

  always @(posedge clk) begin
    drive_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.pitch_drive !== want.pitch_drive) begin
          $display("%0t: pitch_drive exp %h got %h", $time, want.pitch_drive, got.pitch_drive);
          fail_count++;
        end
        if (got.roll_drive !== want.roll_drive) begin
          $display("%0t: roll_drive exp %h got %h", $time, want.roll_drive, got.roll_drive);
          fail_count++;
        end
        if (got.pitch_effort !== want.pitch_effort) begin
          $display("%0t: pitch_effort exp %h got %h", $time, want.pitch_effort,
                   got.pitch_effort);
          fail_count++;
        end
        if (got.roll_effort !== want.roll_effort) begin
          $display("%0t: roll_effort exp %h got %h", $time, want.roll_effort, got.roll_effort);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
      idle_run_cycles <= 0;
    else
      idle_run_cycles <= idle_run_cycles + 1;
    if (idle_run_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_directed_extremes();
    sample_t s;
    // reset gains: only the drive clamp acts
    s = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0};
    send_sample(s);
    drain();
    set_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h7FFF_FFFF, 32'h8000_0000);
    ts_now = 0;
    send_sample('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000});
    send_sample('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000});   // zero dt
    send_sample('{32'h0005_0000, 32'h0, 32'hFFFB_0000, 32'h0, 32'h0000_0001});  // wrap back
    send_sample('{32'h0004_0000, 32'h0, 32'h0004_0001, 32'h0, 32'h0002_0000});  // |eff| near 4
    send_sample('{32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0, 32'hFFFF_FFFF});
    send_sample('{32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0000_0000});
    drain();
    // inverted effort limits: upper wins above it, lower wins otherwise
    set_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFF0_0000, 32'h0010_0000);
    ts_now = 0;
    repeat (6) send_sample(rand_sample(3));
    send_sample(rand_sample(0));
    drain();
    set_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0080_0000, 32'hFF80_0000);
    repeat (6) send_sample(rand_sample($urandom_range(0, 3)));
    drain();
  endtask

  task automatic test_random_settings();
    repeat (5) begin
      set_gains($urandom_range(0, 1) ? rand_word() : $urandom_range(0, 1 << 18),
                rand_word(), rand_word(),
                $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'($urandom_range(4 << 16, 1 << 24)),
                $urandom_range(0, 1) ? 32'h8000_0000 : -32'($urandom_range(4 << 16, 1 << 24)));
      repeat (100) send_sample(rand_sample($urandom_range(0, 9) == 0 ? 0 :
                                           $urandom_range(1, 3)));
      drain();
    end
  endtask

  task automatic test_output_backpressure();
    set_gains(32'h0002_0000, 32'h0000_4000, 32'h0000_1000, 32'h0100_0000, 32'hFF00_0000);
    fork
      begin
        sink_hold = 1;
        repeat (600) @(posedge clk);
        sink_hold = 0;
      end
      repeat (8) send_sample(rand_sample(3));
    join
    drain();
  endtask

  task automatic test_steady_stream();
    sink_jitter = 0;
    src_jitter = 0;
    repeat (60) send_sample(rand_sample(1));
    drain();
  endtask

  initial begin
    gain_kp = '{0, 0}; gain_ki = '{0, 0}; gain_kd = '{0, 0};
    eff_hi = 64'sd2147483647; eff_lo = -64'sd2147483648;
    stamp_last = 0;
    integ = '{0, 0}; prev_err = '{0, 0}; accum = '{0, 0};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed_extremes();
    test_random_settings();
    test_output_backpressure();
    test_steady_stream();
    $display("Covered %0d samples, %0d results: extreme angles, zero and wrapped dt,",
             items_sent, results_seen);
    $display("inverted and open effort limits, long output stall and a gap-free stream.");
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
